### design/ilha_pkg.sv
// shared types, constants and microprogram for the heap allocator
`default_nettype none

package ilha_pkg;

   // heap geometry
   localparam int HEAP_WORDS  = 4096;
   localparam int ALIGN_BYTES = 8;
   localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);
   localparam int WORD_W      = $clog2(HEAP_WORDS);
   localparam int HDR_W       = 16;
   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 15;
   localparam int REQ_W       = SIZE_W + 1;
   localparam int BYTES_W     = $clog2(HEAP_WORDS * ALIGN_BYTES) + 1;
   localparam int SUM_W       = ((BYTES_W > HDR_W) ? BYTES_W : HDR_W) + 2;
   localparam int TOP_BYTES   = HEAP_WORDS * ALIGN_BYTES;
   localparam int RESET_BYTES = (32768 > TOP_BYTES) ? TOP_BYTES : 32768;
   localparam int MIN_BYTES   = 2 * ALIGN_BYTES;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_ZERO     = 3'd2,
      ST_NULLFREE = 3'd3,
      ST_BADFREE  = 3'd4
   } status_type;

   // microprogram step addresses
   typedef enum logic [4:0] {
      S_DISPATCH   = 5'd0,
      S_ACCEPT     = 5'd1,
      S_OP         = 5'd2,
      S_ALLOC      = 5'd3,
      S_WALK       = 5'd4,
      S_HDR        = 5'd5,
      S_ENDCHK     = 5'd6,
      S_LAST       = 5'd7,
      S_SPLITCHK   = 5'd8,
      S_SPLIT_HEAD = 5'd9,
      S_SPLIT_TAIL = 5'd10,
      S_WHOLE      = 5'd11,
      S_MID        = 5'd12,
      S_STEP       = 5'd13,
      S_TAKE       = 5'd14,
      S_GRANT      = 5'd15,
      S_NOFIT      = 5'd16,
      S_ZERO       = 5'd17,
      S_FREE_NULL  = 5'd18,
      S_FREE_CHK   = 5'd19,
      S_FREE_RD    = 5'd20,
      S_FREE_TST   = 5'd21,
      S_FREE_WR    = 5'd22,
      S_FREE_OK    = 5'd23,
      S_NULLFREE   = 5'd24,
      S_BADFREE    = 5'd25,
      S_INIT       = 5'd26
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_INIT,
      C_NO_TAKE,
      C_FREE_OP,
      C_REQ_ZERO,
      C_POS_END,
      C_NEXT_OVER,
      C_NEXT_NE,
      C_LAST_NOFIT,
      C_NO_SPLIT,
      C_MID_FIT,
      C_ADDR_NULL,
      C_ADDR_BAD,
      C_NOT_ALLOC
   } cond_type;

   typedef enum logic [1:0] {
      M_NONE,
      M_READ,
      M_WRITE
   } mem_op_type;

   typedef enum logic [1:0] {
      A_POS,
      A_SPLIT,
      A_FREE,
      A_ZERO
   } addr_sel_type;

   typedef enum logic [2:0] {
      W_INIT,
      W_REQ1,
      W_REMAIN,
      W_MARK,
      W_WHOLE,
      W_CLEAR
   } wdata_sel_type;

   // one control word
   typedef struct packed {
      cond_type      cond;
      step_type      target;
      mem_op_type    mem_op;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          accept;
      logic          adv_pos;
      logic          clear_init;
      logic          emit;
      logic          emit_pos;
      status_type    status;
   } ctl_word_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic init_pend;
      logic no_take;
      logic free_op;
      logic req_zero;
      logic pos_end;
      logic next_over;
      logic next_ne;
      logic last_nofit;
      logic no_split;
      logic mid_fit;
      logic addr_null;
      logic addr_bad;
      logic not_alloc;
      logic out_busy;
   } flags_type;

   // microprogram store
   function automatic ctl_word_type ucode_rom(input step_type s);
      ctl_word_type w;
      w.cond       = C_NEVER;
      w.target     = S_DISPATCH;
      w.mem_op     = M_NONE;
      w.addr_sel   = A_POS;
      w.wdata_sel  = W_INIT;
      w.accept     = 1'b0;
      w.adv_pos    = 1'b0;
      w.clear_init = 1'b0;
      w.emit       = 1'b0;
      w.emit_pos   = 1'b0;
      w.status     = ST_OK;
      case (s)
         S_DISPATCH: begin
            w.cond = C_INIT;       w.target = S_INIT;
         end
         S_ACCEPT: begin
            w.accept = 1'b1;
            w.cond = C_NO_TAKE;    w.target = S_DISPATCH;
         end
         S_OP: begin
            w.cond = C_FREE_OP;    w.target = S_FREE_NULL;
         end
         S_ALLOC: begin
            w.cond = C_REQ_ZERO;   w.target = S_ZERO;
         end
         S_WALK: begin
            w.mem_op = M_READ;     w.addr_sel = A_POS;
            w.cond = C_POS_END;    w.target = S_NOFIT;
         end
         S_HDR: begin
            w.cond = C_NEXT_OVER;  w.target = S_NOFIT;
         end
         S_ENDCHK: begin
            w.cond = C_NEXT_NE;    w.target = S_MID;
         end
         S_LAST: begin
            w.cond = C_LAST_NOFIT; w.target = S_NOFIT;
         end
         S_SPLITCHK: begin
            w.cond = C_NO_SPLIT;   w.target = S_WHOLE;
         end
         S_SPLIT_HEAD: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_POS;   w.wdata_sel = W_REQ1;
         end
         S_SPLIT_TAIL: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_SPLIT; w.wdata_sel = W_REMAIN;
            w.cond = C_ALWAYS;     w.target = S_GRANT;
         end
         S_WHOLE: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_POS;   w.wdata_sel = W_WHOLE;
            w.cond = C_ALWAYS;     w.target = S_GRANT;
         end
         S_MID: begin
            w.cond = C_MID_FIT;    w.target = S_TAKE;
         end
         S_STEP: begin
            w.adv_pos = 1'b1;
            w.cond = C_ALWAYS;     w.target = S_WALK;
         end
         S_TAKE: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_POS;   w.wdata_sel = W_MARK;
            w.cond = C_ALWAYS;     w.target = S_GRANT;
         end
         S_GRANT: begin
            w.emit = 1'b1;         w.emit_pos = 1'b1;    w.status = ST_OK;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_NOFIT: begin
            w.emit = 1'b1;         w.status = ST_NOFIT;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_ZERO: begin
            w.emit = 1'b1;         w.status = ST_ZERO;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_FREE_NULL: begin
            w.cond = C_ADDR_NULL;  w.target = S_NULLFREE;
         end
         S_FREE_CHK: begin
            w.cond = C_ADDR_BAD;   w.target = S_BADFREE;
         end
         S_FREE_RD: begin
            w.mem_op = M_READ;     w.addr_sel = A_FREE;
         end
         S_FREE_TST: begin
            w.cond = C_NOT_ALLOC;  w.target = S_BADFREE;
         end
         S_FREE_WR: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_FREE;  w.wdata_sel = W_CLEAR;
         end
         S_FREE_OK: begin
            w.emit = 1'b1;         w.status = ST_OK;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_NULLFREE: begin
            w.emit = 1'b1;         w.status = ST_NULLFREE;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_BADFREE: begin
            w.emit = 1'b1;         w.status = ST_BADFREE;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         S_INIT: begin
            w.mem_op = M_WRITE;    w.addr_sel = A_ZERO;  w.wdata_sel = W_INIT;
            w.clear_init = 1'b1;
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
         default: begin
            w.cond = C_ALWAYS;     w.target = S_DISPATCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/ilha_hdr_ram.sv
// header memory: one write or one registered read per cycle
`default_nettype none

module ilha_hdr_ram
   import ilha_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [WORD_W-1:0] addr,
   input  wire logic [HDR_W-1:0]  wr_data,
   output logic      [HDR_W-1:0]  rd_data
);

   logic [HDR_W-1:0] mem [HEAP_WORDS];
   logic [HDR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ilha_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module ilha_useq
   import ilha_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire flags_type flags,
   output ctl_word_type   ctl
);

   step_type upc_ff;
   step_type upc_in;
   logic     take_jump;

   // control word for the current step
   assign ctl = ucode_rom(upc_ff);

   // condition select
   always_comb begin
      case (ctl.cond)
         C_NEVER:      take_jump = 1'b0;
         C_ALWAYS:     take_jump = 1'b1;
         C_INIT:       take_jump = flags.init_pend;
         C_NO_TAKE:    take_jump = flags.no_take;
         C_FREE_OP:    take_jump = flags.free_op;
         C_REQ_ZERO:   take_jump = flags.req_zero;
         C_POS_END:    take_jump = flags.pos_end;
         C_NEXT_OVER:  take_jump = flags.next_over;
         C_NEXT_NE:    take_jump = flags.next_ne;
         C_LAST_NOFIT: take_jump = flags.last_nofit;
         C_NO_SPLIT:   take_jump = flags.no_split;
         C_MID_FIT:    take_jump = flags.mid_fit;
         C_ADDR_NULL:  take_jump = flags.addr_null;
         C_ADDR_BAD:   take_jump = flags.addr_bad;
         C_NOT_ALLOC:  take_jump = flags.not_alloc;
         default:      take_jump = 1'b0;
      endcase
   end

   // next step: hold on a blocked result, else jump or fall through
   always_comb begin
      if (ctl.emit && flags.out_busy) begin
         upc_in = upc_ff;
      end else if (take_jump) begin
         upc_in = ctl.target;
      end else begin
         upc_in = step_type'(upc_ff + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_DISPATCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // an accepted beat always moves on to the operation branch
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_ACCEPT && !flags.no_take) |=> (upc_ff == S_OP))
      else $error("sequencer did not advance after accept");

   // a blocked result holds its step
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && flags.out_busy) |=> $stable(upc_ff))
      else $error("sequencer left a blocked result step");

endmodule

`default_nettype wire

### design/ilha_datapath.sv
// datapath: request registers, walk position, header math, heap size, result register
`default_nettype none

module ilha_datapath
   import ilha_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_word_type       ctl,
   output flags_type               flags,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic [SIZE_W-1:0]  req_request_size,
   input  wire logic [ADDR_W-1:0]  req_block_address,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [ADDR_W-1:0]  rsp_payload_address,
   output logic      [2:0]         rsp_status,
   // heap size register
   input  wire logic               csr_wr_en,
   input  wire logic [SIZE_W-1:0]  csr_wr_data,
   // header memory
   output logic                    mem_wr_en,
   output logic                    mem_rd_en,
   output logic      [WORD_W-1:0]  mem_addr,
   output logic      [HDR_W-1:0]   mem_wr_data,
   input  wire logic [HDR_W-1:0]   mem_rd_data
);

   logic                      action_ff;
   logic [REQ_W-1:0]          req_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [BYTES_W-1:0]        pos_ff;
   logic [BYTES_W-1:0]        pos_in;
   logic [BYTES_W-1:0]        heap_bytes_ff;
   logic                      init_pend_ff;
   logic                      rsp_valid_ff;
   logic [ADDR_W-1:0]         rsp_addr_ff;
   status_type                rsp_status_ff;

   logic                      accept;
   logic [REQ_W-1:0]          req_round;
   logic [SIZE_W-1:0]         cfg_size;
   logic                      cfg_ok;
   logic [BYTES_W-1:0]        cfg_bytes;
   logic [HDR_W-1:0]          pv;
   logic                      is_free;
   logic [SUM_W-1:0]          next_pos;
   logic [SUM_W-1:0]          end_pos;
   logic [SUM_W-1:0]          split_pos;
   logic [HDR_W-1:0]          remain;
   logic [ADDR_W-ALIGN_SH-1:0] free_word;
   logic                      load_rsp;

   // accept when the sequencer asks and the heap header is in place
   assign req_stall = !(ctl.accept && !init_pend_ff);
   assign accept    = req_valid && !req_stall;

   // round the request up to the alignment
   assign req_round = (REQ_W'(req_request_size) + REQ_W'(ALIGN_BYTES - 1))
                      & ~REQ_W'(ALIGN_BYTES - 1);

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         req_ff    <= req_round;
         addr_ff   <= req_block_address;
      end
   end

   // header fields
   assign pv        = {mem_rd_data[HDR_W-1:ALIGN_SH], ALIGN_SH'(0)};
   assign is_free   = (mem_rd_data[ALIGN_SH-1:0] == '0);
   assign end_pos   = SUM_W'(heap_bytes_ff);
   assign next_pos  = SUM_W'(pos_ff) + SUM_W'(pv) + SUM_W'(ALIGN_BYTES);
   assign split_pos = SUM_W'(pos_ff) + SUM_W'(req_ff) + SUM_W'(ALIGN_BYTES);
   assign remain    = HDR_W'(SUM_W'(pv) - SUM_W'(req_ff) - SUM_W'(ALIGN_BYTES));
   assign free_word = addr_ff[ADDR_W-1:ALIGN_SH] - 1'b1;

   // walk position
   always_comb begin
      if (accept) begin
         pos_in = '0;
      end else if (ctl.adv_pos) begin
         pos_in = BYTES_W'(next_pos);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // heap size register, rounded down and saturated; small sizes ignored
   assign cfg_size  = {csr_wr_data[SIZE_W-1:ALIGN_SH], ALIGN_SH'(0)};
   assign cfg_ok    = (cfg_size >= SIZE_W'(MIN_BYTES));
   assign cfg_bytes = (SUM_W'(cfg_size) > SUM_W'(TOP_BYTES)) ?
                      BYTES_W'(TOP_BYTES) : BYTES_W'(cfg_size);

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= BYTES_W'(RESET_BYTES);
         init_pend_ff  <= 1'b1;
      end else if (csr_wr_en && cfg_ok) begin
         heap_bytes_ff <= cfg_bytes;
         init_pend_ff  <= 1'b1;
      end else if (ctl.clear_init) begin
         init_pend_ff  <= 1'b0;
      end
   end

   // conditions for the sequencer
   always_comb begin
      flags.init_pend  = init_pend_ff;
      flags.no_take    = !accept;
      flags.free_op    = action_ff;
      flags.req_zero   = (req_ff == '0);
      flags.pos_end    = (SUM_W'(pos_ff) >= end_pos);
      flags.next_over  = (next_pos > end_pos);
      flags.next_ne    = (next_pos != end_pos);
      flags.last_nofit = !is_free || (SUM_W'(req_ff) > SUM_W'(pv));
      flags.no_split   = (SUM_W'(pv) < SUM_W'(req_ff) + SUM_W'(MIN_BYTES));
      flags.mid_fit    = is_free && (SUM_W'(pv) >= SUM_W'(req_ff));
      flags.addr_null  = (addr_ff == '0);
      flags.addr_bad   = (addr_ff[ALIGN_SH-1:0] != '0)
                         || (addr_ff < ADDR_W'(ALIGN_BYTES))
                         || (SUM_W'(addr_ff) > end_pos);
      flags.not_alloc  = !mem_rd_data[0];
      flags.out_busy   = rsp_valid_ff && rsp_stall;
   end

   // header memory port
   assign mem_wr_en = (ctl.mem_op == M_WRITE);
   assign mem_rd_en = (ctl.mem_op == M_READ);

   always_comb begin
      case (ctl.addr_sel)
         A_POS:   mem_addr = pos_ff[ALIGN_SH +: WORD_W];
         A_SPLIT: mem_addr = split_pos[ALIGN_SH +: WORD_W];
         A_FREE:  mem_addr = WORD_W'(free_word);
         A_ZERO:  mem_addr = '0;
         default: mem_addr = '0;
      endcase
   end

   always_comb begin
      case (ctl.wdata_sel)
         W_INIT:   mem_wr_data = HDR_W'(heap_bytes_ff - BYTES_W'(ALIGN_BYTES));
         W_REQ1:   mem_wr_data = HDR_W'(req_ff + 1'b1);
         W_REMAIN: mem_wr_data = remain;
         W_MARK:   mem_wr_data = mem_rd_data | HDR_W'(1);
         W_WHOLE:  mem_wr_data = pv | HDR_W'(1);
         W_CLEAR:  mem_wr_data = mem_rd_data & ~HDR_W'(1);
         default:  mem_wr_data = mem_rd_data;
      endcase
   end

   // result register
   assign load_rsp = ctl.emit && !flags.out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_addr_ff   <= ctl.emit_pos ?
                          ADDR_W'(SUM_W'(pos_ff) + SUM_W'(ALIGN_BYTES)) : '0;
         rsp_status_ff <= ctl.status;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // walk position stays on a header boundary
   a_pos_aligned: assert property (@(posedge clock) disable iff (reset)
      pos_ff[ALIGN_SH-1:0] == '0)
      else $error("walk position off a header boundary");

   // heap size never drops below two words
   a_heap_min: assert property (@(posedge clock) disable iff (reset)
      heap_bytes_ff >= BYTES_W'(MIN_BYTES))
      else $error("heap size below minimum");

   // only a granted allocation carries an address
   a_null_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_addr_ff == '0))
      else $error("failed result carries an address");

endmodule

`default_nettype wire

### design/implicit_list_heap_allocator_core.sv
// top level of the first-fit implicit-list heap allocator
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    action, request_size, block_address
//   rsp_     out  rsp_valid/stall    payload_address, status
//   csr_     in   csr_wr_en          heap_bytes
//
// Free checks for a null or bad address, reads the block header (registered),
// tests its allocated bit and writes that bit clear before the result step.
// Allocate walks the block headers, one registered header read each, then
// writes the chosen block's header before the result step. After reset and
// after each accepted heap_bytes write, the init step writes the heap's first
// header; req_stall stays high until then and drops only in the accepting step.
// A stalled result holds the sequencer on its result step.
`default_nettype none

module implicit_list_heap_allocator_core
   import ilha_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic [SIZE_W-1:0]  req_request_size,
   input  wire logic [ADDR_W-1:0]  req_block_address,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [ADDR_W-1:0]  rsp_payload_address,
   output logic      [2:0]         rsp_status,
   input  wire logic               csr_wr_en,
   input  wire logic [SIZE_W-1:0]  csr_wr_data
);

   ctl_word_type      ctl;
   flags_type         flags;
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [WORD_W-1:0] mem_addr;
   logic [HDR_W-1:0]  mem_wr_data;
   logic [HDR_W-1:0]  mem_rd_data;

   // microcode sequencer
   ilha_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // datapath
   ilha_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .flags               (flags),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mem_wr_en           (mem_wr_en),
      .mem_rd_en           (mem_rd_en),
      .mem_addr            (mem_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_data         (mem_rd_data)
   );

   // header memory
   ilha_hdr_ram u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
